@@ hw/rtl/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, codes and the CRC-16 byte step of the Modbus response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned IDX_W    = 7;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W    = 16;

    localparam logic [POS_W-1:0]  POS_MAX         = '1;
    localparam logic [POS_W-1:0]  DATA_START      = 9'd3;
    localparam logic [POS_W-1:0]  READ_BASE_LEN   = 9'd5;
    localparam logic [POS_W-1:0]  WRITE_REPLY_LEN = 9'd8;
    localparam logic [WORD_W-1:0] CRC_INIT        = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY        = 16'hA001;
    localparam logic [BYTE_W-1:0] FC_WRITE_SINGLE   = 8'd6;
    localparam logic [BYTE_W-1:0] FC_WRITE_MULTIPLE = 8'd16;
    localparam logic [BYTE_W-1:0] EXC_FLAG          = 8'h80;

    typedef enum logic [1:0] {
        OP_READ         = 2'd0,
        OP_WRITE_SINGLE = 2'd1,
        OP_WRITE_MULTI  = 2'd2,
        OP_UNUSED       = 2'd3
    } op_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDR     = 3'd0,
        CFG_OP_KIND        = 3'd1,
        CFG_READ_FUNC_CODE = 3'd2,
        CFG_START_ADDRESS  = 3'd3,
        CFG_WORD_COUNT     = 3'd4,
        CFG_SINGLE_VALUE   = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_EXCEPTION    = 4'd1,
        ST_EXC_CRC      = 4'd2,
        ST_SHORT        = 4'd3,
        ST_OVERSIZED    = 4'd4,
        ST_CRC          = 4'd5,
        ST_ID           = 4'd6,
        ST_FUNC         = 4'd7,
        ST_BYTE_COUNT   = 4'd8,
        ST_ECHO         = 4'd9,
        ST_ADDRESS      = 4'd10,
        ST_COUNT        = 4'd11,
        ST_WRITE_LENGTH = 4'd12
    } status_t;

    typedef struct packed {
        logic [1:0]        op_kind;
        logic [BYTE_W-1:0] slave_addr;
        logic [6:0]        read_func_code;
        logic [WORD_W-1:0] start_address;
        logic [IDX_W-1:0]  word_count;
        logic [WORD_W-1:0] single_value;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]  n;
        logic              crc_zero;
        logic              five_ok;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] func;
        logic [BYTE_W-1:0] third;
        logic [WORD_W-1:0] echo_first;
        logic [WORD_W-1:0] echo_second;
    } frame_info_t;

    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/mrc_in_if.sv @@
// ----------------------------------------------------------------------------
// mrc_in_if
// Byte channel: one received frame byte and its last-byte mark per item.
// ----------------------------------------------------------------------------
interface mrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

@@ hw/rtl/mrc_out_if.sv @@
// ----------------------------------------------------------------------------
// mrc_out_if
// Result channel: a data word or the final frame status per item.
// ----------------------------------------------------------------------------
interface mrc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [3:0]  status;
    logic [7:0]  exception_code;

    modport source (output valid, output result_kind, output word_value,
                    output word_index, output status, output exception_code,
                    input ready);
    modport sink   (input valid, input result_kind, input word_value,
                    input word_index, input status, input exception_code,
                    output ready);
endinterface

@@ hw/rtl/mrc_frame_track.sv @@
// ----------------------------------------------------------------------------
// mrc_frame_track
// Per-frame state: byte position, running CRC, header and echo capture, and
// data word assembly.
// ----------------------------------------------------------------------------
module mrc_frame_track (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                rx_byte,
    input  logic                      frame_end,
    input  mrc_pkg::cfg_t             cfg,
    output mrc_pkg::frame_info_t      info,
    output logic                      word_ready,
    output logic [15:0]               word_value,
    output logic [6:0]                word_index
);
    import mrc_pkg::*;

    logic [POS_W-1:0]  byte_pos_reg, byte_pos_next;
    logic [WORD_W-1:0] crc_reg, crc_next;
    logic              five_ok_reg, five_ok_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [BYTE_W-1:0] func_reg, func_next;
    logic [BYTE_W-1:0] third_reg, third_next;
    logic [WORD_W-1:0] echo1_reg, echo1_next;
    logic [WORD_W-1:0] echo2_reg, echo2_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic [POS_W-1:0]  off;
    logic              in_data;
    logic              read_mode;

    always_comb
    begin
        crc_next   = crc_byte(crc_reg, rx_byte);
        id_next    = (byte_pos_reg == 9'd0) ? rx_byte : id_reg;
        func_next  = (byte_pos_reg == 9'd1) ? rx_byte : func_reg;
        third_next = (byte_pos_reg == 9'd2) ? rx_byte : third_reg;
        echo1_next = echo1_reg;
        echo2_next = echo2_reg;
        five_ok_next = five_ok_reg;
        if (byte_pos_reg == 9'd2)
        begin
            echo1_next = {rx_byte, 8'h00};
        end
        if (byte_pos_reg == 9'd3)
        begin
            echo1_next = {echo1_reg[15:8], rx_byte};
        end
        if (byte_pos_reg == 9'd4)
        begin
            echo2_next   = {rx_byte, 8'h00};
            five_ok_next = (crc_next == '0);
        end
        if (byte_pos_reg == 9'd5)
        begin
            echo2_next = {echo2_reg[15:8], rx_byte};
        end

        read_mode = (cfg.op_kind != OP_WRITE_SINGLE) && (cfg.op_kind != OP_WRITE_MULTI);
        in_data   = (byte_pos_reg >= DATA_START);
        off       = byte_pos_reg - DATA_START;
        hold_next = (in_data && !off[0]) ? rx_byte : hold_reg;
        word_ready = in_data && off[0] && read_mode
                     && (off[POS_W-1:1] < {1'b0, cfg.word_count});
        word_value = {hold_reg, rx_byte};
        word_index = off[IDX_W:1];

        byte_pos_next = (byte_pos_reg == POS_MAX) ? byte_pos_reg : byte_pos_reg + 9'd1;

        info.n           = byte_pos_next;
        info.crc_zero    = (crc_next == '0);
        info.five_ok     = five_ok_next;
        info.id          = id_next;
        info.func        = func_next;
        info.third       = third_next;
        info.echo_first  = echo1_next;
        info.echo_second = echo2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            crc_reg      <= CRC_INIT;
            five_ok_reg  <= 1'b0;
            id_reg       <= '0;
            func_reg     <= '0;
            third_reg    <= '0;
            echo1_reg    <= '0;
            echo2_reg    <= '0;
            hold_reg     <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                byte_pos_reg <= '0;
                crc_reg      <= CRC_INIT;
                five_ok_reg  <= 1'b0;
                id_reg       <= '0;
                func_reg     <= '0;
                third_reg    <= '0;
                echo1_reg    <= '0;
                echo2_reg    <= '0;
                hold_reg     <= '0;
            end
            else
            begin
                byte_pos_reg <= byte_pos_next;
                crc_reg      <= crc_next;
                five_ok_reg  <= five_ok_next;
                id_reg       <= id_next;
                func_reg     <= func_next;
                third_reg    <= third_next;
                echo1_reg    <= echo1_next;
                echo2_reg    <= echo2_next;
                hold_reg     <= hold_next;
            end
        end
    end

endmodule

@@ hw/rtl/mrc_status_eval.sv @@
// ----------------------------------------------------------------------------
// mrc_status_eval
// Frame status at the last byte: first failing check for the configured
// transaction.
// ----------------------------------------------------------------------------
module mrc_status_eval (
    input  mrc_pkg::cfg_t        cfg,
    input  mrc_pkg::frame_info_t info,
    output logic [3:0]           status,
    output logic [7:0]           exception_code
);
    import mrc_pkg::*;

    logic [BYTE_W-1:0] fc;
    logic [POS_W-1:0]  want;
    logic [BYTE_W-1:0] want_bytes;
    logic              is_exc;
    status_t           st;

    always_comb
    begin
        unique case (cfg.op_kind)
            OP_WRITE_SINGLE: fc = FC_WRITE_SINGLE;
            OP_WRITE_MULTI:  fc = FC_WRITE_MULTIPLE;
            default:         fc = {1'b0, cfg.read_func_code};
        endcase
        want_bytes = {cfg.word_count, 1'b0};
        want       = READ_BASE_LEN + {1'b0, want_bytes};
        is_exc     = (info.n >= READ_BASE_LEN) && (info.func == (fc | EXC_FLAG));
        exception_code = '0;

        priority if (is_exc)
        begin
            st = info.five_ok ? ST_EXCEPTION : ST_EXC_CRC;
            exception_code = info.five_ok ? info.third : '0;
        end
        else if (cfg.op_kind == OP_WRITE_SINGLE)
        begin
            priority if (info.n != WRITE_REPLY_LEN) st = ST_WRITE_LENGTH;
            else if (!info.crc_zero) st = ST_CRC;
            else if ((info.id != cfg.slave_addr) || (info.func != FC_WRITE_SINGLE)
                     || (info.echo_first != cfg.start_address)
                     || (info.echo_second != cfg.single_value)) st = ST_ECHO;
            else st = ST_OK;
        end
        else if (cfg.op_kind == OP_WRITE_MULTI)
        begin
            priority if (info.n != WRITE_REPLY_LEN) st = ST_WRITE_LENGTH;
            else if (!info.crc_zero) st = ST_CRC;
            else if (info.id != cfg.slave_addr) st = ST_ID;
            else if (info.func != FC_WRITE_MULTIPLE) st = ST_FUNC;
            else if (info.echo_first != cfg.start_address) st = ST_ADDRESS;
            else if (info.echo_second != {9'd0, cfg.word_count}) st = ST_COUNT;
            else st = ST_OK;
        end
        else
        begin
            priority if (info.n < want) st = ST_SHORT;
            else if (info.n > want) st = ST_OVERSIZED;
            else if (!info.crc_zero) st = ST_CRC;
            else if (info.id != cfg.slave_addr) st = ST_ID;
            else if (info.func != {1'b0, cfg.read_func_code}) st = ST_FUNC;
            else if (info.third != want_bytes) st = ST_BYTE_COUNT;
            else st = ST_OK;
        end
        status = st;
    end

endmodule

@@ hw/rtl/modbus_response_checker_core.sv @@
// ----------------------------------------------------------------------------
// modbus_response_checker_core
// Checks one Modbus RTU response frame byte by byte against the configured
// transaction; emits read data words and a final status item.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                          handshake
//  frame     in    rx_byte[7:0], frame_end                          valid/ready
//  result    out   result_kind, word_value[15:0], word_index[6:0],  valid/ready
//                  status[3:0], exception_code[7:0]
//  cfg       in    cfg_index[2:0], cfg_data[15:0]                   cfg_we
//
//  One byte per cycle; a result appears in the cycle after its byte is taken.
//  The CRC step and the frame checks sit between the byte port and the result
//  register. A byte is taken whenever the result register is empty or drains
//  in the same cycle. Reset clears frame state and loads the register defaults.
// ----------------------------------------------------------------------------
module modbus_response_checker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mrc_pkg::CFG_W-1:0]     cfg_data,
    mrc_in_if.sink                        frame,
    mrc_out_if.source                     result
);
    import mrc_pkg::*;

    cfg_t        cfg_reg;
    frame_info_t info;
    logic        accept;
    logic        word_ready;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [3:0]  st;
    logic [7:0]  exc_code;

    logic        valid_reg;
    logic        kind_reg;
    logic [15:0] value_reg;
    logic [6:0]  index_reg;
    logic [3:0]  status_reg;
    logic [7:0]  exc_reg;

    assign frame.ready = !valid_reg || result.ready;
    assign accept      = frame.valid && frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_addr     <= 8'd1;
            cfg_reg.op_kind        <= OP_READ;
            cfg_reg.read_func_code <= 7'd3;
            cfg_reg.start_address  <= '0;
            cfg_reg.word_count     <= 7'd1;
            cfg_reg.single_value   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ADDR:     cfg_reg.slave_addr     <= cfg_data[7:0];
                CFG_OP_KIND:        cfg_reg.op_kind        <= cfg_data[1:0];
                CFG_READ_FUNC_CODE: cfg_reg.read_func_code <= cfg_data[6:0];
                CFG_START_ADDRESS:  cfg_reg.start_address  <= cfg_data;
                CFG_WORD_COUNT:     cfg_reg.word_count     <= cfg_data[6:0];
                CFG_SINGLE_VALUE:   cfg_reg.single_value   <= cfg_data;
                default:            ;
            endcase
        end
    end

    mrc_frame_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (frame.rx_byte),
        .frame_end  (frame.frame_end),
        .cfg        (cfg_reg),
        .info       (info),
        .word_ready (word_ready),
        .word_value (word_value),
        .word_index (word_index)
    );

    mrc_status_eval u_status (
        .cfg            (cfg_reg),
        .info           (info),
        .status         (st),
        .exception_code (exc_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= frame.frame_end || word_ready;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= frame.frame_end;
            value_reg  <= frame.frame_end ? 16'd0 : word_value;
            index_reg  <= frame.frame_end ? 7'd0 : word_index;
            status_reg <= frame.frame_end ? st : ST_OK;
            exc_reg    <= frame.frame_end ? exc_code : 8'd0;
        end
    end

    assign result.valid          = valid_reg;
    assign result.result_kind    = kind_reg;
    assign result.word_value     = value_reg;
    assign result.word_index     = index_reg;
    assign result.status         = status_reg;
    assign result.exception_code = exc_reg;

`ifndef NO_ASSERTIONS
    a_end_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame.frame_end |=> valid_reg && kind_reg)
        else $error("frame end did not load a status item");

    a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !kind_reg |-> status_reg == ST_OK && exc_reg == 8'd0)
        else $error("data item carries a status");

    a_status_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg |-> value_reg == 16'd0 && index_reg == 7'd0)
        else $error("status item carries word fields");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> frame.ready)
        else $error("byte port stalled with empty result register");

    a_no_write_words: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_reg.op_kind == OP_WRITE_SINGLE || cfg_reg.op_kind == OP_WRITE_MULTI)
        |-> !word_ready)
        else $error("data word raised in a write transaction");
`endif

endmodule
